// ===== sv/lcgksb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgksb_pkg: shared types and constants of the LCG keystream byte scrambler
// Generator constants, seed and register index codes, data widths.
// ----------------------------------------------------------------------------
package lcgksb_pkg;

    // Byte and configuration widths
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Only bits 24..0 of the 48-bit generator reach the keystream byte, and
    // under a multiply-add mod 2^48 the low bits never depend on higher ones.
    // Keep just those bits of the state.
    localparam int KEEP_W  = 25;
    localparam int KEY_LSB = 17;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [KEEP_W-1:0]    gen_state_t;

    // Seed bits 24..16 come from the mid seed register
    localparam int MID_KEEP_W = KEEP_W - CFG_W;
    typedef logic [MID_KEEP_W-1:0] seed_mid_t;

    localparam logic [35:0] LCG_MULT     = 36'h5DEECE66D;
    localparam gen_state_t  LCG_MULT_LOW = LCG_MULT[KEEP_W-1:0];
    localparam gen_state_t  LCG_ADD      = gen_state_t'(4'hB);

    // Configuration register indexes
    localparam cfg_index_t REG_SEED_LOW  = 2'd0;
    localparam cfg_index_t REG_SEED_MID  = 2'd1;
    localparam cfg_index_t REG_SEED_HIGH = 2'd2;

endpackage

// ===== sv/lcgksb_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgksb_gen: keystream generator
// Holds the low generator bits and the line start flag; steps once per byte.
// ----------------------------------------------------------------------------
module lcgksb_gen (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic                   line_end,
    input  lcgksb_pkg::gen_state_t seed,
    output lcgksb_pkg::byte_t      key
);
    import lcgksb_pkg::*;

    gen_state_t             state_reg;
    gen_state_t             state_next;
    gen_state_t             base;
    gen_state_t             prod;
    logic                   line_start_reg;

    // reload from the seed at the start of every line
    assign base       = line_start_reg ? seed : state_reg;
    assign prod       = base * LCG_MULT_LOW;
    assign state_next = prod + LCG_ADD;
    assign key        = state_next[KEY_LSB +: BYTE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_start_reg <= 1'b1;
        end else if (step) begin
            line_start_reg <= line_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_line_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && line_end |=> line_start_reg)
        else $error("line end did not arm a reseed");

    a_mid_line_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !line_end |=> !line_start_reg)
        else $error("reseed armed in mid-line");

    a_idle_holds_line: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(line_start_reg))
        else $error("line start flag moved without a byte");
`endif

endmodule

// ===== sv/lcg_keystream_byte_scrambler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_keystream_byte_scrambler_unit: additive LCG keystream byte scrambler
// Adds the nrand48-style keystream byte to each plain byte, reseeding per line.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  s_       | in        | s_valid / s_ready      | s_plain_byte, s_line_end
//  m_       | out       | m_valid / m_ready      | m_coded_byte, m_coded_line_end
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One byte per cycle while m_ready is high: the generator step (one 25x25
//  truncated multiply-add) and the byte add sit between the generator and
//  output registers. Result appears in the cycle after the input transaction.
//  Reset: seeds clear to zero, output empty, the first byte loads the seed.
//  Stalls: s_ready drops only while a result is held and m_ready is low.
//  cfg_ready is always high; writes to index 3 are dropped.
// ----------------------------------------------------------------------------
module lcg_keystream_byte_scrambler_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lcgksb_pkg::byte_t      s_plain_byte,
    input  logic                   s_line_end,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output lcgksb_pkg::byte_t      m_coded_byte,
    output logic                   m_coded_line_end,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  lcgksb_pkg::cfg_index_t cfg_index,
    input  lcgksb_pkg::cfg_data_t  cfg_data
);
    import lcgksb_pkg::*;

    // Seed storage. Only the bits that reach the kept generator bits are held:
    // all of seed_low and bits 8..0 of seed_mid. seed_high only feeds generator
    // bits above bit 31, which never reach the keystream byte, so its writes
    // are accepted and dropped.
    cfg_data_t  seed_low_reg;
    seed_mid_t  seed_mid_reg;
    gen_state_t seed;

    logic       s_fire;
    logic       m_fire;
    logic       cfg_fire;
    byte_t      key;

    logic       m_valid_reg;
    byte_t      coded_byte_reg;
    logic       coded_line_end_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Accept a new byte whenever the output register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    assign seed = {seed_mid_reg, seed_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_low_reg <= '0;
            seed_mid_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_SEED_LOW: begin
                    seed_low_reg <= cfg_data;
                end
                REG_SEED_MID: begin
                    seed_mid_reg <= cfg_data[MID_KEEP_W-1:0];
                end
                REG_SEED_HIGH: begin
                    // drop: no kept generator bit depends on it
                end
                default: begin
                    // drop: no register at this index
                end
            endcase
        end
    end

    // Generator: advance once per input transaction
    lcgksb_gen u_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_fire),
        .line_end (s_line_end),
        .seed     (seed),
        .key      (key)
    );

    // Output register: hold until the result transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            coded_byte_reg     <= s_plain_byte + key;
            coded_line_end_reg <= s_line_end;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_coded_byte     = coded_byte_reg;
    assign m_coded_line_end = coded_line_end_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted byte produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted over a held result");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && !s_fire |=> !m_valid_reg)
        else $error("result repeated after its transaction");
`endif

endmodule
